// ----- hw/rtl/fci_pkg.sv -----
`timescale 1ns / 1ps

package fci_pkg;

    localparam int MAX_POINTS = 8;
    localparam int SEG_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_W      = 8;
    localparam int DIV_STEPS  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_OFFSET = 3'd4;

    // Partial state of the slope divider: numerator bits still to shift in,
    // running remainder and quotient bits found so far.
    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } div_state_t;

endpackage

// ----- hw/rtl/fci_div_step.sv -----
`timescale 1ns / 1ps

module fci_div_step (
    input  fci_pkg::div_state_t          d_i,
    input  logic [fci_pkg::DIV_W-1:0]    divisor,
    output fci_pkg::div_state_t          d_o
);

    always_comb begin
        logic [fci_pkg::DIV_W:0]   part;
        logic [fci_pkg::DIV_W-1:0] num;
        logic [fci_pkg::DIV_W-1:0] rem;
        logic [fci_pkg::DIV_W-1:0] quo;
        num = d_i.num;
        rem = d_i.rem;
        quo = d_i.quo;
        for (int j = 0; j < fci_pkg::DIV_STEPS; j++) begin
            // shift in the next numerator bit, subtract when it fits
            part = {rem, num[fci_pkg::DIV_W-1]};
            num  = {num[fci_pkg::DIV_W-2:0], 1'b0};
            if (part >= {1'b0, divisor}) begin
                part = part - {1'b0, divisor};
                quo  = {quo[fci_pkg::DIV_W-2:0], 1'b1};
            end else begin
                quo  = {quo[fci_pkg::DIV_W-2:0], 1'b0};
            end
            rem = part[fci_pkg::DIV_W-1:0];
        end
        d_o.num = num;
        d_o.rem = rem;
        d_o.quo = quo;
    end

endmodule

// ----- hw/rtl/fan_curve_interpolator.sv -----
`timescale 1ns / 1ps

// Channel  Ports                                  Dir  Payload
// request  s_valid s_ready s_sample_temp          in   signed Q8.8 temperature
// result   m_valid m_ready m_duty m_saturated     out  signed Q8.8 duty, clip flag
// config   cfg_we cfg_index cfg_wdata             in   register writes, no wait
//
// Seven register stages: offset, segment search, slope setup, two divider
// stages of four quotient bits each, multiply, add and clip. One request per
// cycle while the output is free. Each stage holds only while the stage
// after it is full and held, so bubbles collapse under a stall and s_ready
// stays high while any stage is empty. Reset is synchronous and active low;
// it empties the pipeline and loads the register reset values.

module fan_curve_interpolator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fci_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fci_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_sample_temp,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [15:0]                  m_duty,
    output logic                                m_saturated
);

    localparam int NST = 7;

    // configuration
    logic [fci_pkg::CNT_W-1:0]  point_count_reg;
    logic [63:0]                points_low_reg;
    logic [63:0]                points_high_reg;
    logic                       amb_en_reg;
    logic signed [15:0]         amb_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= fci_pkg::CNT_W'(fci_pkg::MAX_POINTS);
            points_low_reg  <= '0;
            points_high_reg <= '0;
            amb_en_reg      <= 1'b0;
            amb_off_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                fci_pkg::CFG_POINT_COUNT:    point_count_reg <= cfg_wdata[fci_pkg::CNT_W-1:0];
                fci_pkg::CFG_POINTS_LOW:     points_low_reg  <= cfg_wdata;
                fci_pkg::CFG_POINTS_HIGH:    points_high_reg <= cfg_wdata;
                fci_pkg::CFG_AMBIENT_ENABLE: amb_en_reg      <= cfg_wdata[0];
                fci_pkg::CFG_AMBIENT_OFFSET: amb_off_reg     <= $signed(cfg_wdata[15:0]);
                default: ;
            endcase
        end
    end

    logic signed [7:0] px [fci_pkg::MAX_POINTS];
    logic signed [7:0] py [fci_pkg::MAX_POINTS];

    for (genvar k = 0; k < fci_pkg::MAX_POINTS; k++) begin : g_pt
        logic [15:0] bits;
        assign bits  = (k < 4) ? points_low_reg[(k % 4) * 16 +: 16]
                               : points_high_reg[(k % 4) * 16 +: 16];
        assign px[k] = $signed(bits[7:0]);
        assign py[k] = $signed(bits[15:8]);
    end

    logic [fci_pkg::CNT_W-1:0] cnt_eff;
    logic [fci_pkg::SEG_W-1:0] last_idx;

    always_comb begin
        if (point_count_reg == '0) begin
            cnt_eff = fci_pkg::CNT_W'(1);
        end else if (point_count_reg > fci_pkg::CNT_W'(fci_pkg::MAX_POINTS)) begin
            cnt_eff = fci_pkg::CNT_W'(fci_pkg::MAX_POINTS);
        end else begin
            cnt_eff = point_count_reg;
        end
        last_idx = fci_pkg::SEG_W'(cnt_eff - fci_pkg::CNT_W'(1));
    end

    // handshake: a stage loads when it is empty or the next stage loads
    logic [NST-1:0] v_reg;
    logic [NST-1:0] adv;

    always_comb begin
        adv[NST-1] = !v_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= (k == 0) ? s_valid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stage 1: ambient offset
    logic signed [15:0] t1_reg, t1_next;
    logic               sat1_reg, sat1_next;

    always_comb begin
        logic signed [16:0] diff;
        diff      = $signed({s_sample_temp[15], s_sample_temp})
                  - $signed({amb_off_reg[15], amb_off_reg});
        t1_next   = s_sample_temp;
        sat1_next = 1'b0;
        if (amb_en_reg) begin
            if (diff > 17'sd32767) begin
                t1_next   = 16'sh7FFF;
                sat1_next = 1'b1;
            end else if (diff < -17'sd32768) begin
                t1_next   = -16'sh8000;
                sat1_next = 1'b1;
            end else begin
                t1_next   = diff[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            t1_reg   <= t1_next;
            sat1_reg <= sat1_next;
        end
    end

    // stage 2: segment search
    logic signed [15:0]        t2_reg;
    logic                      sat2_reg;
    logic [fci_pkg::SEG_W-1:0] seg2_reg, seg2_next;
    logic                      interp2_reg, interp2_next;
    logic signed [7:0]         by2_reg, by2_next;

    always_comb begin
        logic [fci_pkg::MAX_POINTS-1:0] ge;
        logic [fci_pkg::MAX_POINTS-1:0] lt;
        logic                           found;
        for (int k = 0; k < fci_pkg::MAX_POINTS; k++) begin
            ge[k] = t1_reg >= $signed({px[k], 8'h00});
            lt[k] = t1_reg <  $signed({px[k], 8'h00});
        end
        found     = 1'b0;
        seg2_next = '0;
        for (int i = 0; i < fci_pkg::MAX_POINTS - 1; i++) begin
            if (!found && ge[i] && lt[i+1] && (fci_pkg::CNT_W'(i + 1) < cnt_eff)) begin
                found     = 1'b1;
                seg2_next = fci_pkg::SEG_W'(i);
            end
        end
        if (t1_reg <= $signed({px[0], 8'h00})) begin
            interp2_next = 1'b0;
            by2_next     = py[0];
        end else if (found) begin
            interp2_next = 1'b1;
            by2_next     = py[seg2_next];
        end else begin
            interp2_next = 1'b0;
            by2_next     = py[last_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            t2_reg      <= t1_reg;
            sat2_reg    <= sat1_reg;
            seg2_reg    <= seg2_next;
            interp2_reg <= interp2_next;
            by2_reg     <= by2_next;
        end
    end

    // stage 3: slope operands and distance into the segment
    fci_pkg::div_state_t        div3_reg, div3_next;
    logic [fci_pkg::DIV_W-1:0]  dx3_reg, dx3_next;
    logic                       neg3_reg, neg3_next;
    logic [15:0]                dt3_reg, dt3_next;
    logic                       interp3_reg;
    logic signed [7:0]          by3_reg;
    logic                       sat3_reg;

    always_comb begin
        logic [fci_pkg::SEG_W-1:0] nxt;
        logic signed [8:0]         dx;
        logic signed [8:0]         dy;
        logic signed [8:0]         ady;
        logic signed [16:0]        dt;
        nxt       = seg2_reg + fci_pkg::SEG_W'(1);
        dx        = $signed({px[nxt][7], px[nxt]}) - $signed({px[seg2_reg][7], px[seg2_reg]});
        dy        = $signed({py[nxt][7], py[nxt]}) - $signed({py[seg2_reg][7], py[seg2_reg]});
        ady       = (dy < 0) ? -dy : dy;
        dt        = $signed({t2_reg[15], t2_reg})
                  - $signed({px[seg2_reg][7], px[seg2_reg], 8'h00});
        neg3_next = dy < 0;
        dx3_next  = dx[fci_pkg::DIV_W-1:0];
        dt3_next  = dt[15:0];
        div3_next.num = ady[fci_pkg::DIV_W-1:0];
        div3_next.rem = '0;
        div3_next.quo = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            div3_reg    <= div3_next;
            dx3_reg     <= dx3_next;
            neg3_reg    <= neg3_next;
            dt3_reg     <= dt3_next;
            interp3_reg <= interp2_reg;
            by3_reg     <= by2_reg;
            sat3_reg    <= sat2_reg;
        end
    end

    // stages 4 and 5: slope magnitude, four quotient bits per stage
    fci_pkg::div_state_t        div4_reg, div4_next;
    logic [fci_pkg::DIV_W-1:0]  dx4_reg;
    logic                       neg4_reg;
    logic [15:0]                dt4_reg;
    logic                       interp4_reg;
    logic signed [7:0]          by4_reg;
    logic                       sat4_reg;

    fci_div_step u_div_hi (
        .d_i     (div3_reg),
        .divisor (dx3_reg),
        .d_o     (div4_next)
    );

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            div4_reg    <= div4_next;
            dx4_reg     <= dx3_reg;
            neg4_reg    <= neg3_reg;
            dt4_reg     <= dt3_reg;
            interp4_reg <= interp3_reg;
            by4_reg     <= by3_reg;
            sat4_reg    <= sat3_reg;
        end
    end

    fci_pkg::div_state_t        div5_next;
    logic [fci_pkg::DIV_W-1:0]  quo5_reg;
    logic                       neg5_reg;
    logic [15:0]                dt5_reg;
    logic                       interp5_reg;
    logic signed [7:0]          by5_reg;
    logic                       sat5_reg;

    fci_div_step u_div_lo (
        .d_i     (div4_reg),
        .divisor (dx4_reg),
        .d_o     (div5_next)
    );

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            quo5_reg    <= div5_next.quo;
            neg5_reg    <= neg4_reg;
            dt5_reg     <= dt4_reg;
            interp5_reg <= interp4_reg;
            by5_reg     <= by4_reg;
            sat5_reg    <= sat4_reg;
        end
    end

    // stage 6: multiply slope magnitude by distance
    logic [23:0]        prod6_reg, prod6_next;
    logic               neg6_reg;
    logic signed [7:0]  by6_reg;
    logic               sat6_reg;

    assign prod6_next = interp5_reg ? (24'(quo5_reg) * 24'(dt5_reg)) : 24'd0;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            prod6_reg <= prod6_next;
            neg6_reg  <= neg5_reg;
            by6_reg   <= by5_reg;
            sat6_reg  <= sat5_reg;
        end
    end

    // stage 7: add base, clip, drive the output
    logic signed [15:0] duty_reg, duty_next;
    logic               osat_reg, osat_next;

    always_comb begin
        logic signed [25:0] term;
        logic signed [25:0] sum;
        term = $signed({2'b00, prod6_reg});
        sum  = $signed({{10{by6_reg[7]}}, by6_reg, 8'h00}) + (neg6_reg ? -term : term);
        osat_next = sat6_reg;
        if (sum > 26'sd32767) begin
            duty_next = 16'sh7FFF;
            osat_next = 1'b1;
        end else if (sum < -26'sd32768) begin
            duty_next = -16'sh8000;
            osat_next = 1'b1;
        end else begin
            duty_next = sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            duty_reg <= duty_next;
            osat_reg <= osat_next;
        end
    end

    assign m_duty      = duty_reg;
    assign m_saturated = osat_reg;

endmodule

// ----- dv/fan_curve_interpolator_test.sv -----
`timescale 1ns / 1ps

module fan_curve_interpolator_test;

    localparam int  MAX_GAP      = 17;
    localparam int  DRAIN_CYCLES = 12;
    localparam int  HOLD_CYCLES  = 80;
    localparam int  PHASE_ITEMS  = 62;
    localparam int  RANDOM_PHASES = 9;
    localparam time TIMEOUT_NS   = 1_000_000;

    typedef struct packed {
        logic signed [15:0] duty;
        logic               sat;
    } duty_result_t;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [fci_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [fci_pkg::CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic signed [15:0]              s_sample_temp = '0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic signed [15:0]              m_duty;
    logic                            m_saturated;

    // Shadow copy of the curve registers, loaded with their reset values.
    logic [3:0]             curve_count      = 4'd8;
    logic [63:0]            curve_low        = '0;
    logic [63:0]            curve_high       = '0;
    logic                   ambient_on       = 1'b0;
    logic signed [15:0]     ambient_offset_q = '0;

    duty_result_t           pending_duties[$];
    int                     error_count    = 0;
    int                     requests_sent  = 0;
    int                     results_seen   = 0;
    int                     settings_used  = 0;
    bit                     sender_idle    = 1'b1;
    bit                     receiver_idle  = 1'b1;
    int                     stall_request  = 0;

    fan_curve_interpolator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_temp (s_sample_temp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_saturated   (m_saturated)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TIMEOUT after %0t, %0d results still pending", $time, pending_duties.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int point_x(input int k);
        logic [63:0] word;
        logic [15:0] bits;
        word = (k < 4) ? curve_low : curve_high;
        bits = word[(k % 4) * 16 +: 16];
        return int'($signed(bits[7:0]));
    endfunction

    function automatic int point_y(input int k);
        logic [63:0] word;
        logic [15:0] bits;
        word = (k < 4) ? curve_low : curve_high;
        bits = word[(k % 4) * 16 +: 16];
        return int'($signed(bits[15:8]));
    endfunction

    function automatic int points_in_use();
        int n;
        n = curve_count;
        if (n < 1) n = 1;
        if (n > fci_pkg::MAX_POINTS) n = fci_pkg::MAX_POINTS;
        return n;
    endfunction

    function automatic longint clip_q88(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic duty_result_t predict_duty(input logic signed [15:0] sample);
        duty_result_t r;
        int           n;
        int           i;
        int           dx;
        int           dy;
        longint       t;
        longint       x0;
        longint       x1;
        longint       d;
        bit           found;
        bit           clipped;
        n = points_in_use();
        t = sample;
        clipped = 1'b0;
        found = 1'b0;
        d = 0;
        if (ambient_on) begin
            t = t - ambient_offset_q;
            if (t != clip_q88(t)) clipped = 1'b1;
            t = clip_q88(t);
        end
        if (t <= longint'(point_x(0)) * 256) begin
            d = longint'(point_y(0)) * 256;
            found = 1'b1;
        end else begin
            for (i = 0; i + 1 < n && !found; i++) begin
                x0 = longint'(point_x(i)) * 256;
                x1 = longint'(point_x(i + 1)) * 256;
                if (x0 <= t && t < x1) begin
                    dx = point_x(i + 1) - point_x(i);
                    dy = point_y(i + 1) - point_y(i);
                    found = 1'b1;
                    // Integer division truncates toward zero, as the slope must.
                    if (dx != 0) d = longint'(point_y(i)) * 256 + longint'(dy / dx) * (t - x0);
                    else d = longint'(point_y(i)) * 256;
                end
            end
        end
        if (!found) d = longint'(point_y(n - 1)) * 256;
        if (d != clip_q88(d)) clipped = 1'b1;
        d = clip_q88(d);
        r.duty = d[15:0];
        r.sat = clipped;
        return r;
    endfunction

    function automatic logic [15:0] point_word(input int x, input int y);
        return {8'(y), 8'(x)};
    endfunction

    // Eight points with mostly rising x; now and then an equal or falling step.
    function automatic logic [127:0] make_curve();
        logic [127:0] pts;
        int           x;
        int           y;
        int           k;
        x = -128 + int'($urandom_range(0, 60));
        for (k = 0; k < fci_pkg::MAX_POINTS; k++) begin
            y = int'($urandom_range(0, 255)) - 128;
            pts[k * 16 +: 16] = point_word(x, y);
            if ($urandom_range(0, 11) == 0) x = x - int'($urandom_range(0, 4));
            else x = x + int'($urandom_range(1, 40));
            if (x > 127) x = 127;
            if (x < -128) x = -128;
        end
        return pts;
    endfunction

    function automatic logic [15:0] pick_sample();
        int n;
        int lo;
        int hi;
        int k;
        int target;
        n = points_in_use();
        lo = point_x(0) * 256 - 512;
        hi = point_x(n - 1) * 256 + 512;
        if (hi < lo) begin
            k = lo;
            lo = hi;
            hi = k;
        end
        case ($urandom_range(0, 9)) inside
            [0:5]: target = lo + int'($urandom_range(0, hi - lo));
            [6:7]: begin
                k = int'($urandom_range(0, n - 1));
                target = point_x(k) * 256 + int'($urandom_range(0, 2)) - 1;
            end
            default: return 16'($urandom);
        endcase
        if (ambient_on) target = target + ambient_offset_q;
        return 16'(clip_q88(target));
    endfunction

    function automatic int pick_gap(input bit idle);
        if (!idle || $urandom_range(0, 1) == 0) return 0;
        return int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic write_register(input logic [fci_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            fci_pkg::CFG_POINT_COUNT:    curve_count      = data[3:0];
            fci_pkg::CFG_POINTS_LOW:     curve_low        = data;
            fci_pkg::CFG_POINTS_HIGH:    curve_high       = data;
            fci_pkg::CFG_AMBIENT_ENABLE: ambient_on       = data[0];
            fci_pkg::CFG_AMBIENT_OFFSET: ambient_offset_q = data[15:0];
            default: ;
        endcase
    endtask

    task automatic load_curve(input logic [3:0] count, input logic [63:0] low,
                              input logic [63:0] high, input logic amb_en,
                              input logic [15:0] amb_off);
        write_register(fci_pkg::CFG_POINT_COUNT, 64'(count));
        write_register(fci_pkg::CFG_POINTS_LOW, low);
        write_register(fci_pkg::CFG_POINTS_HIGH, high);
        write_register(fci_pkg::CFG_AMBIENT_ENABLE, 64'(amb_en));
        write_register(fci_pkg::CFG_AMBIENT_OFFSET, 64'(amb_off));
        settings_used++;
    endtask

    // Returns right after the accepting edge with s_valid still high; the next
    // call or wait_for_results decides whether it drops.
    task automatic send_sample(input logic [15:0] temp);
        int gap;
        gap = pick_gap(sender_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_temp <= temp;
        do @(posedge aclk); while (!s_ready);
        pending_duties = {pending_duties, predict_duty(temp)};
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_duties.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : drive_ready
        int  gap;
        int  hold;
        bit  got;
        forever begin
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            gap = pick_gap(receiver_idle);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            got = 1'b0;
            while (!got) begin
                @(posedge aclk);
                got = m_valid || (stall_request != 0);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        duty_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_duties.size() == 0) begin
                report_mismatch($sformatf("result duty=%0d sat=%0b with no request pending",
                                          m_duty, m_saturated));
            end else begin
                want = pending_duties.pop_front();
                if (m_duty !== want.duty)
                    report_mismatch($sformatf("duty got %0d expected %0d", m_duty, want.duty));
                if (m_saturated !== want.sat)
                    report_mismatch($sformatf("saturated got %0b expected %0b (duty %0d)",
                                              m_saturated, want.sat, want.duty));
            end
        end
    end

    task automatic test_reset_defaults();
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh7FFF);
        wait_for_results();
    endtask

    task automatic test_directed_curve();
        logic [63:0] low;
        logic [63:0] high;
        // Segment 2 has equal x and segment 3 falls back; neither can match.
        low  = {point_word(20, 50), point_word(20, 100), point_word(0, 20), point_word(-40, 10)};
        high = {point_word(127, -1), point_word(90, 127), point_word(60, -128), point_word(10, 0)};
        load_curve(4'd8, low, high, 1'b0, 16'h0000);
        send_sample(16'sh8000);
        send_sample(16'(-40 * 256));
        send_sample(16'(-20 * 256 + 7));
        send_sample(16'sh0000);
        send_sample(16'(20 * 256 - 1));
        send_sample(16'(30 * 256));
        send_sample(16'(75 * 256 + 100));
        send_sample(16'(100 * 256));
        send_sample(16'(127 * 256));
        send_sample(16'sh7FFF);
        wait_for_results();
    endtask

    task automatic test_steep_slope();
        load_curve(4'd2, {32'h0, point_word(1, 127), point_word(0, -128)},
                   curve_high, 1'b0, 16'h0000);
        send_sample(16'h00FF);
        send_sample(16'h0100);
        send_sample(16'h0080);
        wait_for_results();
    endtask

    task automatic test_point_count_limits();
        // One point, zero used as one, and a count past the maximum.
        write_register(fci_pkg::CFG_POINT_COUNT, 64'd1);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_for_results();
        write_register(fci_pkg::CFG_POINT_COUNT, 64'd0);
        send_sample(16'd100);
        wait_for_results();
        write_register(fci_pkg::CFG_POINT_COUNT, 64'd15);
        send_sample(16'(70 * 256));
        wait_for_results();
        settings_used += 3;
    endtask

    task automatic test_ambient_offset();
        load_curve(4'd8, curve_low, curve_high, 1'b1, 16'h8000);
        send_sample(16'sh7FFF);
        wait_for_results();
        write_register(fci_pkg::CFG_AMBIENT_OFFSET, 64'h7FFF);
        send_sample(16'sh8000);
        wait_for_results();
        write_register(fci_pkg::CFG_AMBIENT_OFFSET, 64'h0A00);
        send_sample(16'h1000);
        wait_for_results();
        settings_used += 2;
    endtask

    task automatic test_spare_indexes();
        for (int k = int'(fci_pkg::CFG_AMBIENT_OFFSET) + 1; k < (1 << fci_pkg::CFG_IDX_W); k++)
            write_register(fci_pkg::CFG_IDX_W'(k), '1);
        send_sample(16'h0500);
        wait_for_results();
    endtask

    task automatic test_random_curves();
        logic [127:0] pts;
        logic [3:0]   count;
        logic         amb_en;
        logic [15:0]  amb_off;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pts = make_curve();
            count = 4'($urandom_range(2, 8));
            if ($urandom_range(0, 7) == 0) count = 4'd1;
            amb_en = 1'($urandom_range(0, 1));
            amb_off = 16'(int'($urandom_range(0, 10240)) - 5120);
            if ($urandom_range(0, 3) == 0) amb_off = 16'($urandom);
            case (p)
                0: begin
                    pts = {$urandom, $urandom, $urandom, $urandom};
                    count = 4'($urandom_range(0, 15));
                end
                1: begin
                    pts = '1;
                    amb_en = 1'b1;
                    amb_off = 16'h8000;
                end
                2: begin
                    pts = {64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F};
                    amb_en = 1'b1;
                    amb_off = 16'h7FFF;
                end
                default: ;
            endcase
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            load_curve(count, pts[63:0], pts[127:64], amb_en, amb_off);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample());
            wait_for_results();
        end
    endtask

    task automatic test_output_stall();
        logic [127:0] pts;
        pts = make_curve();
        load_curve(4'd8, pts[63:0], pts[127:64], 1'b0, 16'h0000);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        stall_request = HOLD_CYCLES;
        for (int n = 0; n < 40; n++)
            send_sample(pick_sample());
        wait_for_results();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed_curve();
        test_steep_slope();
        test_point_count_limits();
        test_ambient_offset();
        test_spare_indexes();
        test_random_curves();
        test_output_stall();
        if (pending_duties.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_duties.size()));
        $display("Covered %0d samples and %0d duties over %0d curve settings,",
                 requests_sent, results_seen, settings_used);
        $display("with random idling on both sides and one long output stall.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
